// File: hdl/bfa_pkg.sv
// Shared constants, codes and types of the bitmap frame allocator.
package bfa_pkg;

  localparam int NUM_FRAMES    = 32768;
  localparam int FRAME_BYTES   = 4096;
  localparam int MAP_WORD_BITS = 32;

  localparam int MAP_WORDS = (NUM_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int WCNT_W    = WIDX_W + 1;
  localparam int BIT_W     = $clog2(MAP_WORD_BITS);
  localparam int CNT_W     = $clog2(NUM_FRAMES + 1);
  localparam int ADDR_W    = 32;
  localparam int WIDE_W    = ADDR_W + 1;

  localparam logic [ADDR_W-1:0] REGION_USABLE = ADDR_W'(1);

  typedef enum logic [1:0] {
    KIND_REGION  = 2'd0,
    KIND_RESERVE = 2'd1,
    KIND_ALLOC   = 2'd2,
    KIND_FREE    = 2'd3
  } bfa_kind_e;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_SET,
    OP_ALLOC
  } bfa_op_e;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } bfa_state_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] length;
    logic [ADDR_W-1:0] region_type;
  } bfa_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] frame_addr;
    logic              status;
  } bfa_result_t;

  typedef struct packed {
    logic                     re;
    logic [WIDX_W-1:0]        raddr;
    logic                     we;
    logic [WIDX_W-1:0]        waddr;
    logic [MAP_WORD_BITS-1:0] wdata;
  } bfa_ram_req_t;

endpackage

// File: hdl/bfa_item_if.sv
// Input item channel of the bitmap frame allocator.
interface bfa_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] address;
  logic [31:0] length;
  logic [31:0] region_type;

  modport source (output valid, kind, address, length, region_type, input ready);
  modport sink (input valid, kind, address, length, region_type, output ready);
endinterface

// File: hdl/bfa_result_if.sv
// Result item channel of the bitmap frame allocator.
interface bfa_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] frame_addr;
  logic        status;

  modport source (output valid, frame_addr, status, input ready);
  modport sink (input valid, frame_addr, status, output ready);
endinterface

// File: hdl/bfa_map_ram.sv
// Used-bit map memory: one write port, one read port with registered data.
module bfa_map_ram import bfa_pkg::*; (
  input  logic                     clk_i,
  input  bfa_ram_req_t             req_i,
  output logic [MAP_WORD_BITS-1:0] rdata_o
);

  logic [MAP_WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/bfa_walker.sv
// Item decode, map word walk with read-modify-write, and allocation search.
module bfa_walker import bfa_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     item_valid_i,
  output logic                     item_ready_o,
  input  bfa_item_t                item_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output bfa_result_t              res_o,
  output bfa_ram_req_t             ram_req_o,
  input  logic [MAP_WORD_BITS-1:0] ram_rdata_i
);

  localparam logic [WIDE_W-1:0] NUM_FRAMES_WIDE = WIDE_W'(NUM_FRAMES);

  bfa_state_e state_q, state_d;
  logic [WIDX_W-1:0] sweep_q;
  logic [CNT_W-1:0]  limit_q;
  bfa_op_e           op_q;
  logic              empty_q;
  logic [WCNT_W-1:0] rd_word_q;
  logic [WIDX_W-1:0] last_word_q;
  logic [WIDX_W-1:0] lo_word_q;
  logic [BIT_W-1:0]  lo_bit_q;
  logic [BIT_W-1:0]  hi_bit_q;
  logic              p_vld_q;
  logic [WIDX_W-1:0] p_word_q;
  logic              found_q;
  logic [ADDR_W-1:0] addr_q;

  logic [WIDE_W-1:0] sum_c;
  logic [WIDE_W-1:0] end_c;
  logic [ADDR_W-1:0] start_c;
  logic [CNT_W-1:0]  endc_c;
  logic [CNT_W-1:0]  lo_c;
  logic [CNT_W-1:0]  hi_c;
  logic [CNT_W-1:0]  hi_m1_c;
  bfa_op_e           op_c;
  logic              raise_c;
  logic              accept_c;

  logic                     active_c;
  logic                     issue_c;
  logic                     hit_c;
  logic [MAP_WORD_BITS-1:0] mask_c;
  logic [MAP_WORD_BITS-1:0] cand_c;
  logic [MAP_WORD_BITS-1:0] lowbit_c;
  logic [BIT_W-1:0]         bit_idx_c;
  logic [63:0]              hit_byte_c;

  assign accept_c = item_valid_i && item_ready_o;

  always_comb begin
    start_c = item_i.address / FRAME_BYTES;
    unique case (bfa_kind_e'(item_i.kind))
      KIND_REGION:  sum_c = {1'b0, item_i.address} + {1'b0, item_i.length};
      KIND_RESERVE: sum_c = {1'b0, item_i.address} + WIDE_W'(FRAME_BYTES - 1);
      default:      sum_c = {1'b0, item_i.address};
    endcase
    end_c  = sum_c / FRAME_BYTES;
    endc_c = (end_c > NUM_FRAMES_WIDE) ? CNT_W'(NUM_FRAMES) : end_c[CNT_W-1:0];
    lo_c    = '0;
    hi_c    = '0;
    op_c    = OP_CLEAR;
    raise_c = 1'b0;
    unique case (bfa_kind_e'(item_i.kind))
      KIND_REGION: begin
        if (item_i.region_type == REGION_USABLE) begin
          hi_c    = endc_c;
          lo_c    = (start_c < ADDR_W'(endc_c)) ? start_c[CNT_W-1:0] : endc_c;
          raise_c = endc_c > limit_q;
        end
      end
      KIND_RESERVE: begin
        op_c = OP_SET;
        hi_c = endc_c;
      end
      KIND_ALLOC: begin
        op_c = OP_ALLOC;
        hi_c = limit_q;
      end
      KIND_FREE: begin
        if (start_c < ADDR_W'(NUM_FRAMES)) begin
          lo_c = start_c[CNT_W-1:0];
          hi_c = start_c[CNT_W-1:0] + CNT_W'(1);
        end
      end
    endcase
    hi_m1_c = hi_c - CNT_W'(1);
  end

  always_comb begin
    active_c = (state_q == ST_WALK) && p_vld_q;
    mask_c   = '1;
    if (p_word_q == lo_word_q) begin
      mask_c = mask_c & ({MAP_WORD_BITS{1'b1}} << lo_bit_q);
    end
    if (p_word_q == last_word_q) begin
      mask_c = mask_c & ({MAP_WORD_BITS{1'b1}} >> (BIT_W'(MAP_WORD_BITS - 1) - hi_bit_q));
    end
    cand_c   = ~ram_rdata_i & mask_c;
    lowbit_c = cand_c & (~cand_c + MAP_WORD_BITS'(1));
    hit_c    = active_c && (op_q == OP_ALLOC) && (|cand_c);
    bit_idx_c = '0;
    for (int j = 0; j < MAP_WORD_BITS; j++) begin
      if (lowbit_c[j]) begin
        bit_idx_c = bit_idx_c | BIT_W'(j);
      end
    end
    hit_byte_c = (64'(p_word_q) * 64'(MAP_WORD_BITS) + 64'(bit_idx_c)) * 64'(FRAME_BYTES);
    issue_c = (state_q == ST_WALK) && !empty_q && (rd_word_q <= {1'b0, last_word_q})
              && !hit_c;
  end

  always_comb begin
    ram_req_o.re    = issue_c;
    ram_req_o.raddr = rd_word_q[WIDX_W-1:0];
    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = p_word_q;
    ram_req_o.wdata = ram_rdata_i;
    if (state_q == ST_SWEEP) begin
      ram_req_o.we    = 1'b1;
      ram_req_o.waddr = sweep_q;
      ram_req_o.wdata = '1;
    end else if (active_c) begin
      unique case (op_q)
        OP_SET: begin
          ram_req_o.we    = 1'b1;
          ram_req_o.wdata = ram_rdata_i | mask_c;
        end
        OP_CLEAR: begin
          ram_req_o.we    = 1'b1;
          ram_req_o.wdata = ram_rdata_i & ~mask_c;
        end
        OP_ALLOC: begin
          ram_req_o.we    = hit_c;
          ram_req_o.wdata = ram_rdata_i | lowbit_c;
        end
        default: begin
          ram_req_o.we = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SWEEP: if (sweep_q == WIDX_W'(MAP_WORDS - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (item_valid_i) state_d = ST_WALK;
      ST_WALK:  if (!issue_c) state_d = ST_DONE;
      ST_DONE:  if (res_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_SWEEP;
    endcase
  end

  always_comb begin
    item_ready_o     = state_q == ST_IDLE;
    res_valid_o      = state_q == ST_DONE;
    res_o.frame_addr = addr_q;
    res_o.status     = (op_q == OP_ALLOC) && !found_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      sweep_q <= '0;
      limit_q <= '0;
      op_q    <= OP_CLEAR;
      empty_q <= 1'b1;
      p_vld_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SWEEP) begin
        sweep_q <= sweep_q + WIDX_W'(1);
      end
      if (accept_c) begin
        op_q    <= op_c;
        empty_q <= lo_c >= hi_c;
        found_q <= 1'b0;
        p_vld_q <= 1'b0;
        if (raise_c) begin
          limit_q <= endc_c;
        end
      end else if (state_q == ST_WALK) begin
        p_vld_q <= issue_c;
        if (hit_c) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_c) begin
      rd_word_q   <= WCNT_W'(lo_c / MAP_WORD_BITS);
      lo_word_q   <= WIDX_W'(lo_c / MAP_WORD_BITS);
      last_word_q <= WIDX_W'(hi_m1_c / MAP_WORD_BITS);
      lo_bit_q    <= BIT_W'(lo_c % MAP_WORD_BITS);
      hi_bit_q    <= BIT_W'(hi_m1_c % MAP_WORD_BITS);
      addr_q      <= '0;
    end else if (state_q == ST_WALK) begin
      p_word_q <= rd_word_q[WIDX_W-1:0];
      if (issue_c) begin
        rd_word_q <= rd_word_q + WCNT_W'(1);
      end
      if (hit_c) begin
        addr_q <= hit_byte_c[ADDR_W-1:0];
      end
    end
  end

endmodule

// File: hdl/bitmap_frame_allocator.sv
// Bitmap frame allocator top level: channels, map memory, walker and result register.
//
// One used bit per frame lives in a 1024 x 32 map memory that is streamed one word per
// cycle through a read-modify-write path. After reset the block writes every map word
// to all ones and accepts no item in that time. An item holds the block while it walks
// the map words it touches: one for a free, the words of the frame range for a usable
// region (up to 1024), the words from frame 0 to the end of the range for a reserve, and
// the words up to the first free frame for an allocate (up to the frame limit / 32).
// The single read port of the map memory sets this cost. Results leave through an
// output register, so the next item is taken while a result waits to be collected.
module bitmap_frame_allocator import bfa_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  bfa_item_if.sink     item_i,
  bfa_result_if.source result_o
);

  bfa_item_t                item_c;
  bfa_result_t              res_c;
  bfa_ram_req_t             ram_req_c;
  logic [MAP_WORD_BITS-1:0] ram_rdata_c;
  logic                     res_valid_c;
  logic                     res_ready_c;
  logic                     item_ready_c;

  logic              out_vld_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic              out_status_q;

  always_comb begin
    item_c.kind        = item_i.kind;
    item_c.address     = item_i.address;
    item_c.length      = item_i.length;
    item_c.region_type = item_i.region_type;
  end

  bfa_walker u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .item_ready_o (item_ready_c),
    .item_i       (item_c),
    .res_valid_o  (res_valid_c),
    .res_ready_i  (res_ready_c),
    .res_o        (res_c),
    .ram_req_o    (ram_req_c),
    .ram_rdata_i  (ram_rdata_c)
  );

  bfa_map_ram u_map_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req_c),
    .rdata_o (ram_rdata_c)
  );

  assign item_i.ready = item_ready_c;
  assign res_ready_c  = !out_vld_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid_c && res_ready_c) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_c && res_ready_c) begin
      out_addr_q   <= res_c.frame_addr;
      out_status_q <= res_c.status;
    end
  end

  assign result_o.valid      = out_vld_q;
  assign result_o.frame_addr = out_addr_q;
  assign result_o.status     = out_status_q;

endmodule
